/* rtl/prvu_pkg.sv */
`default_nettype none
package prvu_pkg;

  // Slice size limit; the offset counter wraps to zero when it would reach it
  localparam logic [31:0] MAX_VERTICES = 32'd1048576;

  localparam int RANK_W   = 32;
  localparam int DEG_W    = 24;
  localparam int OFS_W    = 20;
  localparam int ACC_W    = 36;
  localparam int DAMP_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_VERTICES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DANGLING_SUM = 2'd2;

  localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd55706;

  typedef struct packed {
    logic [RANK_W-1:0] source_rank;
    logic [DEG_W-1:0]  source_out_degree;
    logic              no_in_edges;
    logic              last_edge;
    logic              last_vertex;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] new_rank;
    logic [OFS_W-1:0]  vertex_offset;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input transaction, seed the divider
    logic div_step;  // one restoring-division iteration
    logic acc_add;   // add the quotient into the accumulator
    logic fin_dang;  // dangling contribution product
    logic fin_mul;   // damped sum and teleport products
    logic load_out;  // final add, saturate, load output, clear/advance
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/prvu_dpath.sv */
`default_nettype none
module prvu_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire prvu_pkg::cmd_t                     cmd,
  input  wire prvu_pkg::in_t                      in_data,
  input  wire logic                               cfg_we,
  input  wire logic [prvu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_data,
  output prvu_pkg::out_t                          out_data
);
  import prvu_pkg::*;

  // Configuration registers
  logic [DAMP_W-1:0] damping_r;
  logic [RANK_W-1:0] inv_r;
  logic [RANK_W-1:0] dang_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r  <= DAMPING_RESET;
      inv_r      <= '0;
      dang_sum_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAMPING:      damping_r  <= cfg_data[DAMP_W-1:0];
        CFG_INV_VERTICES: inv_r      <= cfg_data;
        CFG_DANGLING_SUM: dang_sum_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured edge fields
  logic [DEG_W-1:0] deg_r;
  logic             last_vertex_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      deg_r         <= in_data.source_out_degree;
      last_vertex_r <= in_data.last_vertex;
    end
  end

  // Radix-2 restoring divider: quo_r shifts the dividend out and quotient in
  logic [DEG_W-1:0]  rem_r;
  logic [RANK_W-1:0] quo_r;
  logic [DEG_W:0]    shifted;
  logic [DEG_W+1:0]  diff;

  assign shifted = {rem_r, quo_r[RANK_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, deg_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem_r <= '0;
      quo_r <= in_data.source_rank;
    end else if (cmd.div_step) begin
      if (!diff[DEG_W+1]) begin
        rem_r <= diff[DEG_W-1:0];
        quo_r <= {quo_r[RANK_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEG_W-1:0];
        quo_r <= {quo_r[RANK_W-2:0], 1'b0};
      end
    end
  end

  // Saturating accumulator, Q4.32
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W:0]   acc_sum;

  assign acc_sum = {1'b0, acc_r} + {{(ACC_W-RANK_W+1){1'b0}}, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.load_out) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end
  end

  // Finish stage 1: dangling share = dangling_sum * (1/N), Q0.32
  logic [2*RANK_W-1:0] dang_prod;
  logic [RANK_W-1:0]   dang_r;

  assign dang_prod = {{RANK_W{1'b0}}, dang_sum_r} * {{RANK_W{1'b0}}, inv_r};

  always_ff @(posedge clk) begin
    if (cmd.fin_dang) dang_r <= dang_prod[2*RANK_W-1:RANK_W];
  end

  // Finish stage 2: total*d and (1-d)*(1/N)
  logic [ACC_W:0]           total;
  logic [DAMP_W:0]          one_minus_d;
  logic [ACC_W+DAMP_W:0]    scaled_r;
  logic [RANK_W+DAMP_W:0]   teleport_r;

  assign total       = {1'b0, acc_r} + {{(ACC_W-RANK_W+1){1'b0}}, dang_r};
  assign one_minus_d = {1'b1, {DAMP_W{1'b0}}} - {1'b0, damping_r};

  always_ff @(posedge clk) begin
    if (cmd.fin_mul) begin
      scaled_r   <= {{DAMP_W{1'b0}}, total} * {{(ACC_W+1){1'b0}}, damping_r};
      teleport_r <= {{RANK_W{1'b0}}, one_minus_d} * {{(DAMP_W+1){1'b0}}, inv_r};
    end
  end

  // Finish stage 3: add, scale back by 2^16, saturate
  logic [ACC_W+DAMP_W+1:0] fin_sum;
  logic [ACC_W+1:0]        fin_shr;
  logic [RANK_W-1:0]       rank_sat;

  assign fin_sum  = {1'b0, scaled_r} + {{(ACC_W-RANK_W+1){1'b0}}, teleport_r};
  assign fin_shr  = fin_sum[ACC_W+DAMP_W+1:DAMP_W];
  assign rank_sat = (|fin_shr[ACC_W+1:RANK_W]) ? {RANK_W{1'b1}} : fin_shr[RANK_W-1:0];

  // Vertex offset counter
  logic [OFS_W-1:0] cnt_r;
  logic [OFS_W:0]   cnt_inc;
  logic [OFS_W-1:0] cnt_nxt;

  assign cnt_inc = {1'b0, cnt_r} + {{OFS_W{1'b0}}, 1'b1};

  always_comb begin
    if (last_vertex_r || cnt_inc[OFS_W]
        || ({{(32-OFS_W-1){1'b0}}, cnt_inc} >= MAX_VERTICES)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_inc[OFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load_out) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.new_rank      <= rank_sat;
      out_data.vertex_offset <= cnt_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/prvu_ctrl.sv */
`default_nettype none
module prvu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire prvu_pkg::in_t  in_data,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prvu_pkg::cmd_t      cmd
);
  import prvu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FIN1 = 3'd3;
  localparam logic [2:0] S_FIN2 = 3'd4;
  localparam logic [2:0] S_FIN3 = 3'd5;

  localparam logic [4:0] DIV_LAST = 5'(RANK_W - 1);

  logic [2:0] state_r, state_nxt;
  logic [4:0] div_cnt_r, div_cnt_nxt;
  logic       last_edge_r, last_edge_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    last_edge_nxt = last_edge_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          last_edge_nxt = in_data.last_edge;
          div_cnt_nxt   = '0;
          if (in_data.no_in_edges) begin
            state_nxt = S_FIN1;
          end else if (in_data.source_out_degree == '0) begin
            state_nxt = in_data.last_edge ? S_FIN1 : S_IDLE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 5'd1;
        if (div_cnt_r == DIV_LAST) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = last_edge_r ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        cmd.fin_dang = 1'b1;
        state_nxt    = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = S_FIN3;
      end
      S_FIN3: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      last_edge_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      last_edge_r <= last_edge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register is never overwritten while holding an untaken result
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free) else $error("output overwritten");

  // Every accepted transaction is captured by the datapath
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> cmd.capture) else $error("accepted without capture");

  // Divider runs exactly its full width before accumulating
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == DIV_LAST) |=> state_r == S_ACC)
    else $error("divider did not finish");

  // A result appears only from a load
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out)) else $error("spurious result");

endmodule
`default_nettype wire

/* rtl/pagerank_vertex_update.sv */
// Sequence: an edge that ends its vertex is accepted and then runs through 32 divider
// iterations, 1 accumulate and 3 finish steps; a no-in-link vertex runs only the 3 finish steps.
// Input is taken only while idle, so a new edge waits until the one before it has left the
// radix-2 divider and, if it ended its vertex, the finish steps; a zero out-degree edge skips
// the divider; an untaken result stalls the last finish step of the next vertex.
// Reset (synchronous, rst_n low) clears accumulator, offset counter and config to defaults.
`default_nettype none
module pagerank_vertex_update (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire prvu_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output prvu_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [prvu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import prvu_pkg::*;

  cmd_t cmd;

  // Configuration writes land directly in the datapath's configuration registers
  assign cfg_ready = 1'b1;

  prvu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  prvu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
